// ----- hw/rtl/tpjf_pkg.sv -----
// Shared types and constants for the touch packet jitter filter.
package tpjf_pkg;

    // Serial packet framing bytes
    localparam logic [7:0] HDR_BYTE = 8'hFF;
    localparam logic [7:0] REL_BYTE = 8'hFE;

    // Jump thresholds that pick the smoother weight
    localparam logic [16:0] JUMP_SMALL = 17'd1400;
    localparam logic [16:0] JUMP_MID   = 17'd3000;
    localparam logic [16:0] JUMP_BIG   = 17'd6000;

    localparam logic [19:0] POS_MAX = 20'hFFFFF;

    // Release timer
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

    // Result queue sizing
    localparam int MAX_RESULTS = 3;
    localparam int PUSH_CW     = $clog2(MAX_RESULTS + 1);
    localparam int EVQ_DEPTH   = 4;
    localparam int EVQ_AW      = $clog2(EVQ_DEPTH);

    // Configuration register indexes
    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] CFG_TAP_ENABLE      = CFG_IW'(0);
    localparam logic [CFG_IW-1:0] CFG_RELEASE_TIMEOUT = CFG_IW'(1);

    // Event codes
    localparam logic       EVT_MOTION = 1'b0;
    localparam logic       EVT_BUTTON = 1'b1;
    localparam logic [1:0] BTN_NONE   = 2'd0;
    localparam logic [1:0] BTN_LEFT   = 2'd1;
    localparam logic [1:0] BTN_RIGHT  = 2'd2;
    localparam logic [1:0] BTN_MIDDLE = 2'd3;

    typedef enum logic [1:0] {
        KIND_BYTE  = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_MODEM = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        CHORD_IDLE = 2'd0,
        CHORD_DOWN = 2'd1,
        CHORD_WAIT = 2'd2
    } chord_t;

    typedef struct packed {
        logic        last;
        logic [15:0] pos_y;
        logic [15:0] pos_x;
        logic        pressed;
        logic [1:0]  button_number;
        logic        event_type;
    } result_t;

    // Results produced by one item, slot 0 first
    typedef struct packed {
        logic [PUSH_CW-1:0]              count;
        result_t [MAX_RESULTS-1:0]       item;
    } evq_push_t;

endpackage

// ----- hw/rtl/tpjf_evq.sv -----
// Result queue: takes up to three results per cycle, hands out one per cycle while pop is high.
module tpjf_evq import tpjf_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  evq_push_t push,
    input  logic      pop,
    output result_t   head,
    output logic      head_valid,
    output logic      space
);

    localparam int CW = EVQ_AW + 1;

    result_t           entry_reg [EVQ_DEPTH];
    logic [EVQ_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [EVQ_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;

    // Room for a full burst of results
    assign space      = count_reg <= CW'(EVQ_DEPTH - MAX_RESULTS);
    assign head_valid = count_reg != '0;
    assign head       = entry_reg[rd_ptr_reg];

    // Advance pointers and fill level
    always_comb begin
        wr_ptr_next = wr_ptr_reg + EVQ_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + EVQ_AW'(pop);
        count_next  = count_reg + CW'(push.count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the burst in order
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_RESULTS; i++) begin
            if (i < int'(push.count)) begin
                entry_reg[wr_ptr_reg + EVQ_AW'(i)] <= push.item[i];
            end
        end
    end

endmodule

// ----- hw/rtl/touch_packet_jitter_filter.sv -----
// Touch packet jitter filter: packet parser, smoother, tap timer and button logic.
// An accepted request is held in the input register until the 4-entry result queue
// has room for three results, is processed then, and its first result shows on the
// master side in the cycle after. Throughput is one request per cycle while each
// request gives at most one result and m_tready stays high; a request giving several
// results sends them one after another on the single result port. Reset (aresetn low,
// synchronous) clears all control state and loads the register defaults.
module touch_packet_jitter_filter import tpjf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // Input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // data_byte[7:0], cts_line[8], dsr_line[9], zeros
    input  logic [1:0]        s_tuser,   // kind[1:0]
    // Result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [39:0]       m_tdata,   // event_type[0], button_number[2:1], pressed[3],
                                         // pos_x[19:4], pos_y[35:20], zeros
    output logic              m_tlast,
    // Configuration writes
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [15:0]       cfg_data
);

    // Smoother weight codes
    localparam logic [1:0] W_FINE   = 2'd0;
    localparam logic [1:0] W_MID    = 2'd1;
    localparam logic [1:0] W_COARSE = 2'd2;
    localparam logic [1:0] W_JUMP   = 2'd3;

    // Blend one axis at 16x scale, one bit of headroom for saturation
    function automatic logic [20:0] blend(input logic [19:0] s, input logic [15:0] n,
                                          input logic [1:0] w);
        logic [23:0] m15;
        logic [22:0] m7;
        logic [21:0] m3;
        logic [20:0] r;
        m15 = {s, 4'b0} - 24'(s);
        m7  = {s, 3'b0} - 23'(s);
        m3  = {s, 2'b0} - 22'(s);
        case (w)
            W_FINE:   r = 21'(m15[23:4]) + 21'(n);
            W_MID:    r = 21'(m7[22:3]) + 21'({n, 1'b0});
            W_COARSE: r = 21'(m3[21:2]) + 21'({n, 2'b0});
            W_JUMP:   r = 21'({n, 4'b0});
            default:  r = 21'({n, 4'b0});
        endcase
        return r;
    endfunction

    // Configuration
    logic        tap_enable_reg;
    logic [15:0] timeout_reg;

    // Input register
    logic        in_valid_reg, in_valid_next;
    kind_t       in_kind_reg;
    logic [7:0]  in_byte_reg;
    logic        in_cts_reg, in_dsr_reg;

    // Block state
    logic [2:0]  pos_reg, pos_next;
    logic        long_reg, long_next;
    logic [7:0]  byte0_reg, byte1_reg, byte2_reg;
    logic [19:0] smooth_x_reg, smooth_x_next;
    logic [19:0] smooth_y_reg, smooth_y_next;
    logic        touch_reg, touch_next;
    logic        timer_active_reg, timer_active_next;
    logic [15:0] timer_count_reg, timer_count_next;
    logic        left_reg, left_next;
    logic        right_reg, right_next;
    chord_t      chord_reg, chord_next;

    // Processing handshake
    logic        accept, fire, evq_space, evq_valid;
    evq_push_t   push;
    result_t     head;

    // Working values
    logic [PUSH_CW-1:0] n;
    logic        long_v, st, done;
    logic [2:0]  pos_inc;
    logic [15:0] nx, ny, cur_x, cur_y, dx, dy;
    logic [16:0] jump;
    logic [1:0]  wsel;
    logic [20:0] cand_x, cand_y;
    logic [15:0] cnt_inc;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && evq_space;
    assign s_tready  = !in_valid_reg || fire;
    assign accept    = s_tvalid && s_tready;

    // Hold the input request until the queue has room
    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    // Coordinates of a long packet; the final byte arrives with this request
    assign nx      = {byte1_reg, byte0_reg};
    assign ny      = {in_byte_reg, byte2_reg};
    assign cur_x   = smooth_x_reg[19:4];
    assign cur_y   = smooth_y_reg[19:4];
    assign dx      = (nx >= cur_x) ? nx - cur_x : cur_x - nx;
    assign dy      = (ny >= cur_y) ? ny - cur_y : cur_y - ny;
    assign jump    = 17'(dx) + 17'(dy);
    assign wsel    = (jump < JUMP_SMALL) ? W_FINE :
                     (jump < JUMP_MID)   ? W_MID :
                     (jump < JUMP_BIG)   ? W_COARSE : W_JUMP;
    assign cand_x  = blend(smooth_x_reg, nx, wsel);
    assign cand_y  = blend(smooth_y_reg, ny, wsel);
    assign cnt_inc = (timer_count_reg < COUNT_MAX) ? timer_count_reg + 16'd1
                                                   : timer_count_reg;
    assign long_v  = (pos_reg == 3'd1) ? (in_byte_reg != REL_BYTE) : long_reg;
    assign pos_inc = pos_reg + 3'd1;

    // Work out next state and the results of the request in the input register
    always_comb begin
        pos_next          = pos_reg;
        long_next         = long_reg;
        smooth_x_next     = smooth_x_reg;
        smooth_y_next     = smooth_y_reg;
        touch_next        = touch_reg;
        timer_active_next = timer_active_reg;
        timer_count_next  = timer_count_reg;
        left_next         = left_reg;
        right_next        = right_reg;
        chord_next        = chord_reg;
        push              = '0;
        n                 = '0;
        st                = 1'b0;
        done              = 1'b0;

        if (fire) begin
            case (in_kind_reg)
                KIND_BYTE: begin
                    if (pos_reg == 3'd0) begin
                        if (in_byte_reg == HDR_BYTE) begin
                            pos_next = 3'd1;
                        end
                    end else begin
                        long_next = long_v;
                        pos_next  = pos_inc;
                        if (pos_inc >= (long_v ? 3'd5 : 3'd3)) begin
                            pos_next          = 3'd0;
                            timer_active_next = 1'b0;
                            timer_count_next  = '0;
                            st                = long_v;
                            if (long_v) begin
                                if (wsel == W_COARSE || wsel == W_JUMP) begin
                                    st = touch_reg;
                                end
                                smooth_x_next = cand_x[20] ? POS_MAX : cand_x[19:0];
                                smooth_y_next = cand_y[20] ? POS_MAX : cand_y[19:0];
                                push.item[n].event_type    = EVT_MOTION;
                                push.item[n].button_number = BTN_NONE;
                                push.item[n].pressed       = 1'b0;
                                n = n + 1'b1;
                            end
                            if (st != touch_reg && tap_enable_reg) begin
                                push.item[n].event_type    = EVT_BUTTON;
                                push.item[n].button_number = BTN_LEFT;
                                push.item[n].pressed       = st | left_reg;
                                n = n + 1'b1;
                                touch_next = st;
                                if (st) begin
                                    timer_active_next = 1'b1;
                                    timer_count_next  = '0;
                                end
                            end
                        end
                    end
                end
                KIND_TICK: begin
                    if (timer_active_reg) begin
                        timer_count_next = cnt_inc;
                        if (cnt_inc >= timeout_reg) begin
                            timer_active_next = 1'b0;
                            timer_count_next  = '0;
                            if (touch_reg) begin
                                push.item[n].event_type    = EVT_BUTTON;
                                push.item[n].button_number = BTN_LEFT;
                                push.item[n].pressed       = 1'b0;
                                n = n + 1'b1;
                                touch_next = 1'b0;
                            end
                        end
                    end
                end
                KIND_MODEM: begin
                    // Both lines from idle: press the emulated middle button
                    if (in_cts_reg && in_dsr_reg && !left_reg && !right_reg &&
                        chord_reg == CHORD_IDLE) begin
                        push.item[n].event_type    = EVT_BUTTON;
                        push.item[n].button_number = BTN_MIDDLE;
                        push.item[n].pressed       = 1'b1;
                        n = n + 1'b1;
                        chord_next = CHORD_DOWN;
                    end
                    // A line dropped: release the chord, wait for both lines down
                    if (chord_next != CHORD_IDLE && (!in_cts_reg || !in_dsr_reg)) begin
                        if (chord_next != CHORD_WAIT) begin
                            push.item[n].event_type    = EVT_BUTTON;
                            push.item[n].button_number = BTN_MIDDLE;
                            push.item[n].pressed       = 1'b0;
                            n = n + 1'b1;
                            chord_next = CHORD_WAIT;
                        end
                        if (in_cts_reg || in_dsr_reg) begin
                            done = 1'b1;
                        end else begin
                            chord_next = CHORD_IDLE;
                        end
                    end
                    if (!done) begin
                        if (in_cts_reg != left_reg) begin
                            push.item[n].event_type    = EVT_BUTTON;
                            push.item[n].button_number = BTN_LEFT;
                            push.item[n].pressed       = in_cts_reg;
                            n = n + 1'b1;
                            left_next = in_cts_reg;
                        end
                        if (in_dsr_reg != right_reg) begin
                            push.item[n].event_type    = EVT_BUTTON;
                            push.item[n].button_number = BTN_RIGHT;
                            push.item[n].pressed       = in_dsr_reg;
                            n = n + 1'b1;
                            right_next = in_dsr_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // All results of one request report the updated position
        for (int i = 0; i < MAX_RESULTS; i++) begin
            push.item[i].pos_x = smooth_x_next[19:4];
            push.item[i].pos_y = smooth_y_next[19:4];
            push.item[i].last  = (i == int'(n) - 1);
        end
        push.count = n;
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_enable_reg   <= 1'b0;
            timeout_reg      <= TIMEOUT_RESET;
            in_valid_reg     <= 1'b0;
            pos_reg          <= '0;
            long_reg         <= 1'b0;
            smooth_x_reg     <= '0;
            smooth_y_reg     <= '0;
            touch_reg        <= 1'b0;
            timer_active_reg <= 1'b0;
            timer_count_reg  <= '0;
            left_reg         <= 1'b0;
            right_reg        <= 1'b0;
            chord_reg        <= CHORD_IDLE;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TAP_ENABLE:      tap_enable_reg <= cfg_data[0];
                    CFG_RELEASE_TIMEOUT: timeout_reg    <= cfg_data;
                    default: begin
                    end
                endcase
            end
            in_valid_reg     <= in_valid_next;
            pos_reg          <= pos_next;
            long_reg         <= long_next;
            smooth_x_reg     <= smooth_x_next;
            smooth_y_reg     <= smooth_y_next;
            touch_reg        <= touch_next;
            timer_active_reg <= timer_active_next;
            timer_count_reg  <= timer_count_next;
            left_reg         <= left_next;
            right_reg        <= right_next;
            chord_reg        <= chord_next;
        end
    end

    // Input payload and packet bytes
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_kind_reg <= kind_t'(s_tuser[1:0]);
            in_byte_reg <= s_tdata[7:0];
            in_cts_reg  <= s_tdata[8];
            in_dsr_reg  <= s_tdata[9];
        end
        if (fire && in_kind_reg == KIND_BYTE) begin
            case (pos_reg)
                3'd1:    byte0_reg <= in_byte_reg;
                3'd2:    byte1_reg <= in_byte_reg;
                3'd3:    byte2_reg <= in_byte_reg;
                default: begin
                end
            endcase
        end
    end

    tpjf_evq u_evq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .head_valid (evq_valid),
        .space      (evq_space)
    );

    assign m_tvalid = evq_valid;
    assign m_tdata  = {4'b0, head.pos_y, head.pos_x, head.pressed, head.button_number,
                       head.event_type};
    assign m_tlast  = head.last;

`ifndef SYNTH
    a_timer_needs_touch: assert property (@(posedge aclk) disable iff (!aresetn)
        timer_active_reg |-> touch_reg)
        else $error("release timer running without touch contact");

    a_idle_timer_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !timer_active_reg |-> timer_count_reg == '0)
        else $error("stopped release timer holds a count");

    a_chord_both_down: assert property (@(posedge aclk) disable iff (!aresetn)
        chord_reg == CHORD_DOWN |-> (left_reg && right_reg))
        else $error("chord held without both finger buttons down");

    a_packet_position: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 3'd4)
        else $error("packet position past the last byte");
`endif

endmodule
